// ===== rtl/imd_dec_pkg.sv =====
`default_nettype none
package imd_dec_pkg;

	localparam int AddrBits = 32;
	localparam int MapDepth = 256;
	localparam int BaseW = ((AddrBits > 32) ? AddrBits : 32) + 1;
	localparam int ModSteps = 9;

	localparam logic [7:0] EotByte = 8'h1A;
	localparam logic [7:0] CylMapBit = 8'h80;
	localparam logic [7:0] HeadMapBit = 8'h40;
	localparam logic [7:0] ModeLimit = 8'd6;
	localparam logic [7:0] SizeLimit = 8'd7;
	localparam logic [13:0] BaseSector = 14'd128;
	localparam logic [7:0] MagicText [4] = '{8'h49, 8'h4D, 8'h44, 8'h20};

	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_FILL = 2'd1;
	localparam logic [1:0] KIND_DONE = 2'd2;
	localparam logic [1:0] KIND_ERROR = 2'd3;

	localparam logic [3:0] ERR_EOF_HEADER = 4'd0;
	localparam logic [3:0] ERR_BAD_MAGIC = 4'd1;
	localparam logic [3:0] ERR_BAD_MODE = 4'd2;
	localparam logic [3:0] ERR_EOF_TRACK = 4'd3;
	localparam logic [3:0] ERR_BAD_SIZE = 4'd4;
	localparam logic [3:0] ERR_ZERO_SECT = 4'd5;
	localparam logic [3:0] ERR_BAD_RECORD = 4'd6;
	localparam logic [3:0] ERR_NO_TRACKS = 4'd7;
	localparam logic [3:0] ERR_ADDR_OVF = 4'd8;

	typedef enum logic [4:0] {
		ST_HEADER, ST_MODE, ST_CYL, ST_HEAD, ST_COUNT, ST_SIZE, ST_SMAP, ST_MOD,
		ST_CMAP, ST_HMAP, ST_LOOK, ST_ADDR, ST_RECORD, ST_DATA, ST_FILL,
		ST_DONE, ST_ERROR
	} state_t;

	typedef struct packed {
		logic hdr_step;
		logic load_flags;
		logic load_count;
		logic load_size;
		logic mod_start;
		logic mod_run;
		logic map_wr;
		logic entry_inc;
		logic entry_clr;
		logic base_add;
		logic any_set;
		logic off_inc;
		logic off_clr;
		logic addr_calc;
		logic emit;
		logic fill_zero;
		logic [1:0] kind;
		logic [3:0] err;
	} dp_cmd_t;

	typedef struct packed {
		logic is_eot;
		logic hdr_short;
		logic magic_ok;
		logic mode_bad;
		logic size_bad;
		logic count_zero;
		logic ovf;
		logic rec0;
		logic rec1;
		logic rec2;
		logic last_entry;
		logic last_byte;
		logic mod_done;
		logic cmap;
		logic hmap;
		logic any_seen;
		logic out_stall;
	} dp_stat_t;

	function automatic logic [13:0] sec_bytes(input logic [2:0] shift);
		return BaseSector << shift;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/imd_dec_ram.sv =====
`default_nettype none
module imd_dec_ram #(
	parameter int Width = 8,
	parameter int Depth = 256
) (
	input wire logic clk,
	input wire logic wr_en,
	input wire logic [$clog2(Depth)-1:0] wr_addr,
	input wire logic [Width-1:0] wr_data,
	input wire logic [$clog2(Depth)-1:0] rd_addr,
	output logic [Width-1:0] rd_data
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule
`default_nettype wire

// ===== rtl/imd_dec_dp.sv =====
`default_nettype none
module imd_dec_dp
	import imd_dec_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [7:0] data_byte,
	input wire logic out_ready,
	input wire dp_cmd_t cmd,
	output dp_stat_t stat,
	output logic out_valid,
	output logic [1:0] kind,
	output logic [31:0] address,
	output logic [13:0] run_length,
	output logic [7:0] byte_value,
	output logic [3:0] error_code
);
	logic [2:0] hdr_cnt_q;
	logic magic_q;
	logic [BaseW-1:0] base_q;
	logic [BaseW-1:0] sec_addr_q;
	logic [7:0] count_q;
	logic [2:0] size_q;
	logic cmap_q;
	logic hmap_q;
	logic [7:0] entry_q;
	logic [13:0] off_q;
	logic any_q;
	logic [8:0] mod_v_q;
	logic [7:0] mod_r_q;
	logic [3:0] mod_cnt_q;
	logic out_valid_q;
	logic [7:0] slot;
	logic [13:0] sb;
	logic [BaseW-1:0] track_sum;
	logic [BaseW-1:0] track_span;
	logic [8:0] mod_t;
	logic [8:0] mod_sub;

	assign sb = sec_bytes(size_q);
	assign track_span = BaseW'({count_q, 7'b0}) << size_q;
	assign track_sum = base_q + (BaseW'({count_q, 7'b0}) << data_byte[2:0]);
	assign mod_t = {mod_r_q, mod_v_q[8]};
	assign mod_sub = mod_t - {1'b0, count_q};

	imd_dec_ram #(.Width(8), .Depth(MapDepth)) u_map (
		.clk(clk),
		.wr_en(cmd.map_wr),
		.wr_addr(entry_q),
		.wr_data(mod_r_q),
		.rd_addr(entry_q),
		.rd_data(slot)
	);

	always_comb begin
		stat.is_eot = data_byte == EotByte;
		stat.hdr_short = !hdr_cnt_q[2];
		stat.magic_ok = magic_q;
		stat.mode_bad = data_byte >= ModeLimit;
		stat.size_bad = data_byte >= SizeLimit;
		stat.count_zero = count_q == 8'd0;
		stat.ovf = (track_sum >> AddrBits) != '0;
		stat.rec0 = data_byte == 8'd0;
		stat.rec1 = data_byte == 8'd1;
		stat.rec2 = data_byte == 8'd2;
		stat.last_entry = ({1'b0, entry_q} + 9'd1) >= {1'b0, count_q};
		stat.last_byte = ({1'b0, off_q} + 15'd1) >= {1'b0, sb};
		stat.mod_done = mod_cnt_q == 4'(ModSteps);
		stat.cmap = cmap_q;
		stat.hmap = hmap_q;
		stat.any_seen = any_q;
		stat.out_stall = out_valid_q && !out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_cnt_q <= '0;
			magic_q <= 1'b1;
			base_q <= '0;
			count_q <= '0;
			size_q <= '0;
			cmap_q <= 1'b0;
			hmap_q <= 1'b0;
			entry_q <= '0;
			off_q <= '0;
			any_q <= 1'b0;
			mod_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.hdr_step && !hdr_cnt_q[2]) begin
				if (data_byte != MagicText[hdr_cnt_q[1:0]]) begin
					magic_q <= 1'b0;
				end
				hdr_cnt_q <= hdr_cnt_q + 3'd1;
			end
			if (cmd.load_flags) begin
				cmap_q <= (data_byte & CylMapBit) != 8'd0;
				hmap_q <= (data_byte & HeadMapBit) != 8'd0;
			end
			if (cmd.load_count) begin
				count_q <= data_byte;
			end
			if (cmd.load_size) begin
				size_q <= data_byte[2:0];
			end
			if (cmd.entry_clr) begin
				entry_q <= '0;
			end else if (cmd.entry_inc) begin
				entry_q <= entry_q + 8'd1;
			end
			if (cmd.base_add) begin
				base_q <= base_q + track_span;
			end
			if (cmd.any_set) begin
				any_q <= 1'b1;
			end
			if (cmd.off_clr) begin
				off_q <= '0;
			end else if (cmd.off_inc) begin
				off_q <= off_q + 14'd1;
			end
			if (cmd.mod_start) begin
				mod_cnt_q <= '0;
			end else if (cmd.mod_run) begin
				mod_cnt_q <= mod_cnt_q + 4'd1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mod_start) begin
			mod_v_q <= {1'b0, data_byte} + {1'b0, count_q} - 9'd1;
			mod_r_q <= '0;
		end else if (cmd.mod_run) begin
			mod_v_q <= {mod_v_q[7:0], 1'b0};
			mod_r_q <= (mod_t >= {1'b0, count_q}) ? mod_sub[7:0] : mod_t[7:0];
		end
		if (cmd.addr_calc) begin
			sec_addr_q <= base_q + (BaseW'({slot, 7'b0}) << size_q);
		end
		if (cmd.emit) begin
			kind <= cmd.kind;
			error_code <= '0;
			address <= '0;
			run_length <= '0;
			byte_value <= '0;
			case (cmd.kind)
				KIND_BYTE: begin
					address <= 32'(sec_addr_q + BaseW'(off_q));
					byte_value <= data_byte;
				end
				KIND_FILL: begin
					address <= 32'(sec_addr_q);
					run_length <= sb;
					byte_value <= cmd.fill_zero ? 8'd0 : data_byte;
				end
				KIND_DONE: begin
					address <= 32'(base_q);
				end
				default: begin
					error_code <= cmd.err;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

// ===== rtl/imd_dec_ctrl.sv =====
`default_nettype none
module imd_dec_ctrl
	import imd_dec_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic end_of_stream,
	input wire dp_stat_t stat,
	output logic in_ready,
	output dp_cmd_t cmd,
	output state_t state
);
	state_t state_q;
	state_t state_d;
	logic take;
	logic accepting;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HEADER;
		end else begin
			state_q <= state_d;
		end
	end

	assign state = state_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			ST_MOD, ST_LOOK, ST_ADDR: accepting = 1'b0;
			default: accepting = 1'b1;
		endcase
		in_ready = accepting && !stat.out_stall;
		take = in_valid && in_ready;

		case (state_q)
			ST_MOD: begin
				if (stat.mod_done) begin
					cmd.map_wr = 1'b1;
					cmd.entry_inc = 1'b1;
					if (stat.last_entry) begin
						cmd.entry_clr = 1'b1;
						state_d = stat.cmap ? ST_CMAP : (stat.hmap ? ST_HMAP : ST_LOOK);
					end else begin
						state_d = ST_SMAP;
					end
				end else begin
					cmd.mod_run = 1'b1;
				end
			end
			ST_LOOK: state_d = ST_ADDR;
			ST_ADDR: begin
				cmd.addr_calc = 1'b1;
				state_d = ST_RECORD;
			end
			default: ;
		endcase

		if (take && state_q != ST_DONE && state_q != ST_ERROR) begin
			if (end_of_stream) begin
				cmd.emit = 1'b1;
				cmd.kind = KIND_ERROR;
				state_d = ST_ERROR;
				if (state_q == ST_HEADER) begin
					cmd.err = ERR_EOF_HEADER;
				end else if (state_q == ST_MODE) begin
					if (stat.any_seen) begin
						cmd.kind = KIND_DONE;
						state_d = ST_DONE;
					end else begin
						cmd.err = ERR_NO_TRACKS;
					end
				end else begin
					cmd.err = ERR_EOF_TRACK;
				end
			end else begin
				case (state_q)
					ST_HEADER: begin
						if (stat.is_eot) begin
							if (stat.hdr_short || !stat.magic_ok) begin
								cmd.emit = 1'b1;
								cmd.kind = KIND_ERROR;
								cmd.err = ERR_BAD_MAGIC;
								state_d = ST_ERROR;
							end else begin
								state_d = ST_MODE;
							end
						end else begin
							cmd.hdr_step = 1'b1;
						end
					end
					ST_MODE: begin
						if (stat.mode_bad) begin
							cmd.emit = 1'b1;
							cmd.kind = KIND_ERROR;
							cmd.err = ERR_BAD_MODE;
							state_d = ST_ERROR;
						end else begin
							state_d = ST_CYL;
						end
					end
					ST_CYL: state_d = ST_HEAD;
					ST_HEAD: begin
						cmd.load_flags = 1'b1;
						state_d = ST_COUNT;
					end
					ST_COUNT: begin
						cmd.load_count = 1'b1;
						state_d = ST_SIZE;
					end
					ST_SIZE: begin
						if (stat.size_bad || stat.count_zero || stat.ovf) begin
							cmd.emit = 1'b1;
							cmd.kind = KIND_ERROR;
							cmd.err = stat.size_bad ? ERR_BAD_SIZE :
								(stat.count_zero ? ERR_ZERO_SECT : ERR_ADDR_OVF);
							state_d = ST_ERROR;
						end else begin
							cmd.load_size = 1'b1;
							cmd.entry_clr = 1'b1;
							state_d = ST_SMAP;
						end
					end
					ST_SMAP: begin
						cmd.mod_start = 1'b1;
						state_d = ST_MOD;
					end
					ST_CMAP, ST_HMAP: begin
						cmd.entry_inc = 1'b1;
						if (stat.last_entry) begin
							cmd.entry_clr = 1'b1;
							state_d = (state_q == ST_CMAP && stat.hmap) ? ST_HMAP : ST_LOOK;
						end
					end
					ST_RECORD: begin
						if (stat.rec0) begin
							cmd.emit = 1'b1;
							cmd.kind = KIND_FILL;
							cmd.fill_zero = 1'b1;
						end else if (stat.rec1) begin
							cmd.off_clr = 1'b1;
							state_d = ST_DATA;
						end else if (stat.rec2) begin
							state_d = ST_FILL;
						end else begin
							cmd.emit = 1'b1;
							cmd.kind = KIND_ERROR;
							cmd.err = ERR_BAD_RECORD;
							state_d = ST_ERROR;
						end
					end
					ST_DATA: begin
						cmd.emit = 1'b1;
						cmd.kind = KIND_BYTE;
						if (stat.last_byte) begin
							cmd.off_clr = 1'b1;
						end else begin
							cmd.off_inc = 1'b1;
						end
					end
					ST_FILL: begin
						cmd.emit = 1'b1;
						cmd.kind = KIND_FILL;
					end
					default: ;
				endcase
				// sector finished: advance entry, close track on last one
				if ((state_q == ST_RECORD && stat.rec0) || state_q == ST_FILL ||
					(state_q == ST_DATA && stat.last_byte)) begin
					cmd.entry_inc = 1'b1;
					if (stat.last_entry) begin
						cmd.entry_clr = 1'b1;
						cmd.base_add = 1'b1;
						cmd.any_set = 1'b1;
						state_d = ST_MODE;
					end else begin
						state_d = ST_LOOK;
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/disk_image_track_decoder_unit.sv =====
// Output: a result is registered at the transfer of the byte that causes it,
//   visible in the next cycle.
// Throughput: one byte per cycle unless a result stalls; input pauses for each
//   sector-map byte (9-step remainder unit) and each sector's map RAM lookup.
// Reset: arst_n asynchronous, active low; decoder returns to header parsing.
`default_nettype none
module disk_image_track_decoder_unit
	import imd_dec_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [7:0] data_byte,
	input wire logic end_of_stream,
	output logic out_valid,
	input wire logic out_ready,
	output logic [1:0] kind,
	output logic [31:0] address,
	output logic [13:0] run_length,
	output logic [7:0] byte_value,
	output logic [3:0] error_code
);
	dp_cmd_t cmd;
	dp_stat_t stat;
	state_t state;

	imd_dec_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.end_of_stream(end_of_stream),
		.stat(stat),
		.in_ready(in_ready),
		.cmd(cmd),
		.state(state)
	);

	imd_dec_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.data_byte(data_byte),
		.out_ready(out_ready),
		.cmd(cmd),
		.stat(stat),
		.out_valid(out_valid),
		.kind(kind),
		.address(address),
		.run_length(run_length),
		.byte_value(byte_value),
		.error_code(error_code)
	);

	a_no_take_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> !(out_valid && !out_ready))
		else $error("transfer accepted while result stalled");

	a_fill_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_FILL) |-> $onehot(run_length))
		else $error("fill run length not a sector size");

	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(state == ST_DONE || state == ST_ERROR) |=>
		(state == ST_DONE || state == ST_ERROR) && !cmd.emit)
		else $error("decoder left terminal state");

	a_map_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state == ST_MOD || state == ST_LOOK || state == ST_ADDR) |-> !in_ready)
		else $error("input taken during internal step");
endmodule
`default_nettype wire
